// ----- hdl/fsfs_pkg.sv -----
`timescale 1ns / 1ps
package fsfs_pkg;
   localparam int ValW = 17;
   localparam int AccW = 29;
   localparam int FracBits = 16;

   typedef enum logic [2:0] {
      DIV_INCL_MIN,
      DIV_COV_MIN,
      DIV_INCL_MAX,
      DIV_COV_MAX,
      DIV_PRI_MIN,
      DIV_PRI_MAX
   } div_sel_type;

   typedef struct packed {
      logic start;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
   } dp_status_type;
endpackage

// ----- hdl/fuzzy_set_fit_scores.sv -----
`timescale 1ns / 1ps
// A non-final request only updates the running sums and column extremes of its set.
// The final request of a set starts six serial divisions, each cut short when the
// numerator or denominator is zero, and the response is valid after the last of them.
// Throughput: one request per cycle within a set; no request is taken until the response goes.
// The restoring divider, one quotient bit per cycle over 45 bits, sets the end-of-set time.
// Synchronous reset clears all sums, the mode register and the handshake state.
module fuzzy_set_fit_scores (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_data,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: data_value, column_code, fuzzy_column, outcome_value, pad.
   input  logic [39:0] req_tdata,
   // tuser: last_case.
   input  logic req_tuser,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: inclusion_min, coverage_min, inclusion_max, coverage_max, pri_min, pri_max, pad.
   output logic [103:0] rsp_tdata,
   // tuser: no_column_error.
   output logic rsp_tuser
);
   logic mode_ff;
   logic accept;
   fsfs_pkg::dp_cmd_type cmd;
   fsfs_pkg::dp_status_type status;
   fsfs_pkg::div_sel_type div_sel;
   logic clear_set;
   logic [16:0] res [6];
   logic absent;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else if (csr_valid) mode_ff <= csr_data;
   end

   assign accept = req_tvalid && req_tready;

   fsfs_datapath u_dp (
      .clock(clock), .reset(reset), .item_valid(accept),
      .data_value(req_tdata[16:0]), .column_code(req_tdata[20:17]),
      .fuzzy_column(req_tdata[21]), .outcome_value(req_tdata[38:22]),
      .last_column(req_tlast), .necessity_mode(mode_ff), .div_sel(div_sel),
      .cmd(cmd), .clear_set(clear_set), .status(status), .result_ff(res),
      .absent_ff(absent)
   );

   fsfs_control u_ctl (
      .clock(clock), .reset(reset), .final_item(accept && req_tlast && req_tuser),
      .rsp_taken(rsp_tvalid && rsp_tready), .status(status), .cmd(cmd),
      .div_sel(div_sel), .clear_set(clear_set), .in_ready(req_tready),
      .out_valid(rsp_tvalid)
   );

   assign rsp_tuser = absent;
   assign rsp_tdata = absent ? '0 :
      {2'b0, res[5], res[4], res[3], res[2], res[1], res[0]};
endmodule

// ----- hdl/fsfs_divider.sv -----
`timescale 1ns / 1ps
module fsfs_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [fsfs_pkg::AccW-1:0] num,
   input  logic [fsfs_pkg::AccW-1:0] den,
   output logic done,
   output logic [fsfs_pkg::ValW-1:0] quotient
);
   localparam int NW = fsfs_pkg::AccW + fsfs_pkg::FracBits;
   localparam int CW = $clog2(NW + 1);
   localparam logic [fsfs_pkg::ValW-1:0] One = fsfs_pkg::ValW'(1 << fsfs_pkg::FracBits);

   logic [NW-1:0] dividend_ff;
   logic [NW-1:0] quot_ff;
   logic [fsfs_pkg::AccW:0] rem_ff;
   logic [fsfs_pkg::AccW-1:0] den_ff;
   logic [CW-1:0] count_ff;
   logic run_ff;
   logic done_ff;
   logic [fsfs_pkg::ValW-1:0] quotient_ff;
   logic special_ff;
   logic [fsfs_pkg::ValW-1:0] special_val_ff;
   logic [fsfs_pkg::AccW:0] trial;
   logic [fsfs_pkg::AccW:0] shifted;

   assign shifted = {rem_ff[fsfs_pkg::AccW-1:0], dividend_ff[NW-1]};
   assign trial = shifted - {1'b0, den_ff};
   assign done = done_ff;
   assign quotient = quotient_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dividend_ff <= {num, fsfs_pkg::FracBits'(0)};
            den_ff <= den;
            rem_ff <= '0;
            quot_ff <= '0;
            count_ff <= CW'(NW);
            special_ff <= (num == '0) || (den == '0);
            special_val_ff <= (num == '0) ? '0 : One;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (special_ff || count_ff == '0) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
               if (special_ff) begin
                  quotient_ff <= special_val_ff;
               end else if (quot_ff > NW'(One)) begin
                  quotient_ff <= One;
               end else begin
                  quotient_ff <= quot_ff[fsfs_pkg::ValW-1:0];
               end
            end else begin
               dividend_ff <= dividend_ff << 1;
               count_ff <= count_ff - 1'b1;
               if (!trial[fsfs_pkg::AccW]) begin
                  rem_ff <= trial;
                  quot_ff <= {quot_ff[NW-2:0], 1'b1};
               end else begin
                  rem_ff <= shifted;
                  quot_ff <= {quot_ff[NW-2:0], 1'b0};
               end
            end
         end
      end
   end
endmodule

// ----- hdl/fsfs_datapath.sv -----
`timescale 1ns / 1ps
module fsfs_datapath (
   input  logic clock,
   input  logic reset,
   input  logic item_valid,
   input  logic [16:0] data_value,
   input  logic [3:0] column_code,
   input  logic fuzzy_column,
   input  logic [16:0] outcome_value,
   input  logic last_column,
   input  logic necessity_mode,
   input  fsfs_pkg::div_sel_type div_sel,
   input  fsfs_pkg::dp_cmd_type cmd,
   input  logic clear_set,
   output fsfs_pkg::dp_status_type status,
   output logic [16:0] result_ff [6],
   output logic absent_ff
);
   localparam int AW = fsfs_pkg::AccW;
   localparam logic [16:0] One = 17'(1 << fsfs_pkg::FracBits);
   localparam logic [AW-1:0] AccMax = '1;

   logic [16:0] cmin_ff, cmax_ff;
   logic present_ff;
   logic [AW-1:0] osum_ff, smin_ff, smax_ff, spm_ff, spx_ff, prim_ff, prix_ff;
   logic [16:0] dclamp, oclamp, v;
   logic [AW-1:0] num, den, basev;
   logic div_done;
   logic [16:0] q;

   function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a, input logic [16:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + (AW + 1)'(b);
      return s[AW] ? AccMax : s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] sub0(input logic [AW-1:0] a, input logic [AW-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   always_comb begin
      dclamp = (data_value > One) ? One : data_value;
      oclamp = (outcome_value > One) ? One : outcome_value;
      if (fuzzy_column) begin
         v = (column_code == 4'd1) ? One - dclamp : dclamp;
      end else begin
         v = ({14'd0, column_code} == {1'b0, data_value} + 18'd1) ? One : '0;
      end
      basev = necessity_mode ? osum_ff : smin_ff;
      case (div_sel)
         fsfs_pkg::DIV_INCL_MIN: begin num = spm_ff; den = smin_ff; end
         fsfs_pkg::DIV_COV_MIN: begin num = spm_ff; den = osum_ff; end
         fsfs_pkg::DIV_INCL_MAX: begin num = spx_ff; den = smax_ff; end
         fsfs_pkg::DIV_COV_MAX: begin num = spx_ff; den = osum_ff; end
         fsfs_pkg::DIV_PRI_MIN: begin
            num = sub0(spm_ff, prim_ff);
            den = sub0(basev, prim_ff);
         end
         default: begin num = sub0(spx_ff, prix_ff); den = sub0(osum_ff, prix_ff); end
      endcase
   end

   fsfs_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.start), .num(num), .den(den),
      .done(div_done), .quotient(q)
   );

   assign status.done = div_done;

   always_ff @(posedge clock) begin
      if (cmd.load) result_ff[div_sel] <= q;
      if (reset || clear_set) begin
         cmin_ff <= '1; cmax_ff <= '0; present_ff <= 1'b0;
         osum_ff <= '0; smin_ff <= '0; smax_ff <= '0; spm_ff <= '0; spx_ff <= '0;
         prim_ff <= '0; prix_ff <= '0; absent_ff <= 1'b0;
      end else if (item_valid) begin
         if (last_column) begin
            cmin_ff <= '1; cmax_ff <= '0; present_ff <= 1'b0;
            osum_ff <= sat_add(osum_ff, oclamp);
            if (present_ff || column_code != '0) begin
               logic [16:0] mn, mx, pmn, pxn, oth, a1, a2;
               mn = (column_code != '0 && v < cmin_ff) ? v : cmin_ff;
               mx = (column_code != '0 && v > cmax_ff) ? v : cmax_ff;
               pmn = (mn < oclamp) ? mn : oclamp;
               pxn = (mx < oclamp) ? mx : oclamp;
               oth = necessity_mode ? One - mn : One - oclamp;
               a1 = (pmn < oth) ? pmn : oth;
               a2 = (pxn < One - mx) ? pxn : One - mx;
               smin_ff <= sat_add(smin_ff, mn);
               smax_ff <= sat_add(smax_ff, mx);
               spm_ff <= sat_add(spm_ff, pmn);
               spx_ff <= sat_add(spx_ff, pxn);
               prim_ff <= sat_add(prim_ff, a1);
               prix_ff <= sat_add(prix_ff, a2);
            end else begin
               absent_ff <= 1'b1;
            end
         end else if (column_code != '0) begin
            if (v < cmin_ff) cmin_ff <= v;
            if (v > cmax_ff) cmax_ff <= v;
            present_ff <= 1'b1;
         end
      end
   end
endmodule

// ----- hdl/fsfs_control.sv -----
`timescale 1ns / 1ps
module fsfs_control (
   input  logic clock,
   input  logic reset,
   input  logic final_item,
   input  logic rsp_taken,
   input  fsfs_pkg::dp_status_type status,
   output fsfs_pkg::dp_cmd_type cmd,
   output fsfs_pkg::div_sel_type div_sel,
   output logic clear_set,
   output logic in_ready,
   output logic out_valid
);
   typedef enum logic [1:0] {IDLE, START, WAIT, SHOW} state_type;
   state_type state_ff;
   fsfs_pkg::div_sel_type div_sel_ff;

   assign div_sel = div_sel_ff;
   assign in_ready = (state_ff == IDLE);
   assign cmd.start = (state_ff == START);
   assign cmd.load = (state_ff == WAIT) && status.done;
   assign out_valid = (state_ff == SHOW);
   assign clear_set = (state_ff == SHOW) && rsp_taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         div_sel_ff <= fsfs_pkg::DIV_INCL_MIN;
      end else begin
         unique case (state_ff)
            IDLE: if (final_item) begin
               state_ff <= START;
               div_sel_ff <= fsfs_pkg::DIV_INCL_MIN;
            end
            START: state_ff <= WAIT;
            WAIT: if (status.done) begin
               if (div_sel_ff == fsfs_pkg::DIV_PRI_MAX) state_ff <= SHOW;
               else begin
                  div_sel_ff <= fsfs_pkg::div_sel_type'(div_sel_ff + 3'd1);
                  state_ff <= START;
               end
            end
            SHOW: if (rsp_taken) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) cmd.start |=> !cmd.start)
      else $error("divider start repeated");
   assert property (@(posedge clock) disable iff (reset) out_valid |-> !in_ready)
      else $error("input open while result pending");
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> div_sel <= fsfs_pkg::DIV_PRI_MAX)
      else $error("bad divider select");
endmodule

// ----- sim/tb_fuzzy_set_fit_scores.sv -----
`timescale 1ns / 1ps
typedef struct packed {
   logic [16:0] incl_min;
   logic [16:0] cov_min;
   logic [16:0] incl_max;
   logic [16:0] cov_max;
   logic [16:0] pri_min;
   logic [16:0] pri_max;
   logic        no_col;
} fit_scores_type;

class fit_score_board;
   localparam longint One = 64'd65536;
   localparam longint AccMax = (64'd1 << 29) - 1;
   bit      necessity;
   longint  cmin, cmax;
   bit      present;
   longint  o_sum, s_min, s_max, s_pm, s_px, p_min, p_max;
   bit      absent_seen;
   fit_scores_type pending[$];
   int      mismatches;

   function void clear_set();
      cmin = 64'h1FFFF;
      cmax = 0;
      present = 0;
      o_sum = 0;
      s_min = 0;
      s_max = 0;
      s_pm = 0;
      s_px = 0;
      p_min = 0;
      p_max = 0;
      absent_seen = 0;
   endfunction

   function longint sat(longint a, longint b);
      return (a + b > AccMax) ? AccMax : a + b;
   endfunction

   function longint lo(longint a, longint b);
      return a < b ? a : b;
   endfunction

   function longint sub0(longint a, longint b);
      return a > b ? a - b : 0;
   endfunction

   function logic [16:0] fit_ratio(longint num, longint den);
      longint q;
      if (num == 0) return 17'd0;
      if (den == 0) return 17'(One);
      q = (num << 16) / den;
      return (q > One) ? 17'(One) : 17'(q);
   endfunction

   function void note_request(logic [16:0] data, logic [3:0] code, bit fuzzy,
                              logic [16:0] outc_raw, bit last_col, bit last_cs);
      longint v, outc, pm, px, other, base;
      fit_scores_type r;
      outc = lo(outc_raw, One);
      if (fuzzy) begin
         v = lo(data, One);
         if (code == 1) v = One - v;
      end else begin
         v = (longint'(code) == longint'(data) + 1) ? One : 0;
      end
      if (code != 0) begin
         if (v < cmin) cmin = v;
         if (v > cmax) cmax = v;
         present = 1;
      end
      if (!last_col) return;
      o_sum = sat(o_sum, outc);
      if (present) begin
         pm = lo(cmin, outc);
         px = lo(cmax, outc);
         other = necessity ? One - cmin : One - outc;
         s_min = sat(s_min, cmin);
         s_max = sat(s_max, cmax);
         s_pm = sat(s_pm, pm);
         s_px = sat(s_px, px);
         p_min = sat(p_min, lo(pm, other));
         p_max = sat(p_max, lo(px, One - cmax));
      end else begin
         absent_seen = 1;
      end
      cmin = 64'h1FFFF;
      cmax = 0;
      present = 0;
      if (!last_cs) return;
      r = '0;
      if (absent_seen) begin
         r.no_col = 1;
      end else begin
         base = necessity ? o_sum : s_min;
         r.incl_min = fit_ratio(s_pm, s_min);
         r.cov_min = fit_ratio(s_pm, o_sum);
         r.incl_max = fit_ratio(s_px, s_max);
         r.cov_max = fit_ratio(s_px, o_sum);
         r.pri_min = fit_ratio(sub0(s_pm, p_min), sub0(base, p_min));
         r.pri_max = fit_ratio(sub0(s_px, p_max), sub0(o_sum, p_max));
      end
      pending.push_back(r);
      clear_set();
   endfunction

   function void check_response(fit_scores_type got);
      fit_scores_type exp_r;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected response %p", got);
         return;
      end
      exp_r = pending.pop_front();
      if (got != exp_r) begin
         mismatches++;
         if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", exp_r, got);
      end
   endfunction
endclass

module tb_fuzzy_set_fit_scores;
   logic         clock = 0;
   logic         reset = 1;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic         csr_data = 0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [39:0]  req_tdata = '0;
   logic         req_tuser = 0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [103:0] rsp_tdata;
   logic         rsp_tuser;

   fit_score_board board;
   int send_idle = 0;
   int recv_idle = 0;
   int sent_items = 0;

   fuzzy_set_fit_scores i_dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      fit_scores_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.incl_min = rsp_tdata[16:0];
            got.cov_min = rsp_tdata[33:17];
            got.incl_max = rsp_tdata[50:34];
            got.cov_max = rsp_tdata[67:51];
            got.pri_min = rsp_tdata[84:68];
            got.pri_max = rsp_tdata[101:85];
            got.no_col = rsp_tuser;
            board.check_response(got);
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic write_mode(bit m);
      csr_valid <= 1;
      csr_data <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.necessity = m;
      csr_valid <= 0;
   endtask

   task automatic send_request(logic [16:0] data, logic [3:0] code, bit fuzzy,
                               logic [16:0] outc, bit last_col, bit last_cs);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {1'b0, outc, fuzzy, code, data};
      req_tlast <= last_col;
      req_tuser <= last_cs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(data, code, fuzzy, outc, last_col, last_cs);
      sent_items++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [16:0] rand_member();
      case ($urandom_range(5))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(17'h1FFFF, 65537));
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   task automatic send_case(bit last_cs);
      int ncol;
      logic [16:0] outc;
      bit fuzzy;
      logic [3:0] code;
      logic [16:0] data;
      ncol = $urandom_range(4, 1);
      outc = rand_member();
      for (int c = 0; c < ncol; c++) begin
         fuzzy = 1'($urandom_range(1));
         code = ($urandom_range(7) == 0) ? 4'd0 : 4'($urandom_range(15));
         if (fuzzy) data = rand_member();
         else data = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(15));
         send_request(data, code, fuzzy, ($urandom_range(3) == 0) ? rand_member() : outc,
                      c == ncol - 1, (c == ncol - 1) ? last_cs : 1'($urandom_range(1)));
      end
   endtask

   task automatic random_sets(int items);
      int stop_at;
      stop_at = sent_items + items;
      while (sent_items < stop_at) begin
         int ncase;
         ncase = $urandom_range(6, 1);
         for (int k = 0; k < ncase; k++) send_case(k == ncase - 1);
      end
   endtask

   initial begin
      board = new();
      board.clear_set();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed sets: extremes, negation, crisp match, absent case, clamping.
      write_mode(0);
      send_request(17'd65536, 4'd1, 1, 17'd0, 0, 1);
      send_request(17'h1FFFF, 4'd2, 1, 17'h1FFFF, 1, 0);
      send_request(17'd3, 4'd4, 0, 17'd30000, 1, 0);
      send_request(17'd3, 4'd15, 0, 17'd40000, 1, 1);
      send_request(17'd0, 4'd0, 1, 17'd100, 1, 1);
      send_request(17'd5, 4'd0, 0, 17'd0, 1, 0);
      send_request(17'd20000, 4'd3, 1, 17'd50000, 1, 1);
      send_request(17'd0, 4'd0, 0, 17'd0, 1, 0);
      send_request(17'd0, 4'd1, 1, 17'd0, 1, 1);
      send_request(17'd1234, 4'd1, 1, 17'd65535, 0, 0);
      send_request(17'd60000, 4'd9, 1, 17'd65535, 1, 1);
      drain();
      write_mode(1);
      send_request(17'd10000, 4'd1, 1, 17'd20000, 0, 0);
      send_request(17'd40000, 4'd2, 1, 17'd20000, 1, 0);
      send_request(17'h10000, 4'd1, 0, 17'd65536, 1, 0);
      send_request(17'h1FFFE, 4'd15, 0, 17'd1, 1, 1);
      drain();

      send_idle = 8;
      recv_idle = 65;
      random_sets(500);
      drain();
      write_mode(0);
      send_idle = 65;
      recv_idle = 8;
      random_sets(500);
      drain();
      write_mode(1);
      send_idle = 0;
      recv_idle = 0;
      random_sets(500);
      drain();

      if (board.mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

// ----- fuzzy_set_fit_scores.f -----
hdl/fsfs_pkg.sv
hdl/fsfs_divider.sv
hdl/fsfs_datapath.sv
hdl/fsfs_control.sv
hdl/fuzzy_set_fit_scores.sv
sim/tb_fuzzy_set_fit_scores.sv
